### sv/citc_pkg.sv
// Package for the C identifier token counter: sizes, keyword table and record type.
// Has no dependencies; every other file but citc_ifs imports it.
package citc_pkg;

    localparam int MAX_LINE = 128;
    localparam int TOKEN_LIMIT = (MAX_LINE > 255) ? 255 : MAX_LINE;
    localparam int HEAD_BYTES = 8;
    localparam int COUNT_MAX = 127;
    localparam int KEYWORD_COUNT = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // Keywords as string literals (first letter in the highest used byte).
    localparam logic [63:0] KW_TEXT [KEYWORD_COUNT] = '{
        "if", "do", "int", "for",
        "auto", "char", "case", "long", "enum", "goto", "void", "else",
        "break", "const", "short", "float", "union", "while",
        "double", "return", "extern", "signed", "sizeof", "static", "struct",
        "switch",
        "default", "typedef",
        "continue", "register", "unsigned", "volatile"
    };

    localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
        4'd2, 4'd2, 4'd3, 4'd3,
        4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
        4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
        4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
        4'd6,
        4'd7, 4'd7,
        4'd8, 4'd8, 4'd8, 4'd8
    };

    // One closed token or line end, handed from the front to the back.
    typedef struct packed {
        logic       closed;
        logic       ident;
        logic [7:0] len;
        logic       line_end;
    } t_token_rec;

    // Reorders a keyword literal so that its first letter sits in bits 7:0,
    // the same layout the token head uses.
    function automatic logic [63:0] kw_little(input logic [63:0] text, input logic [3:0] len);
        logic [63:0] res;
        res = '0;
        for (int k = 0; k < HEAD_BYTES; k++) begin
            if (k < int'(len)) begin
                res[8*k +: 8] = text[8*(int'(len) - 1 - k) +: 8];
            end
        end
        return res;
    endfunction

    // Bytes past the token length are zero in the head, and terminators never
    // enter it, so a whole-word compare plus a length compare is exact.
    function automatic logic kw_match(input logic [63:0] head, input logic [7:0] len);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            if (len == {4'd0, KW_LEN[k]} && head == kw_little(KW_TEXT[k], KW_LEN[k])) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic is_word_byte(input logic [7:0] c);
        return (c == CH_UNDERSCORE) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

endpackage

### sv/citc_ifs.sv
// Handshake interfaces for the byte input and the token result channels.
// Depends on nothing; used by the top level of the token counter.
interface citc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

interface citc_result_if;
    logic       valid;
    logic       ready;
    logic       token_closed;
    logic       is_identifier;
    logic [7:0] token_length;
    logic [6:0] identifier_total;
    logic       line_end;

    modport source (output valid, output token_closed, output is_identifier,
                    output token_length, output identifier_total, output line_end,
                    input ready);
    modport sink (input valid, input token_closed, input is_identifier,
                  input token_length, input identifier_total, input line_end,
                  output ready);
endinterface

### sv/citc_front.sv
// Front end: gathers token bytes and classifies each token when it ends.
// Depends on citc_pkg.
module citc_front
    import citc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_ch,
    input  logic       i_full,
    output logic       o_ready,
    output logic       o_push,
    output t_token_rec o_rec
);

    logic [63:0] r_head, n_head;
    logic [7:0]  r_len, n_len;
    logic        r_ok, n_ok;
    logic        accept, ends_line, is_sep;

    assign o_ready = !i_full;
    assign accept = i_valid && o_ready;
    assign ends_line = (i_ch == CH_NUL) || (i_ch == CH_NEWLINE);
    assign is_sep = ends_line || (i_ch == CH_SPACE);

    always_comb begin
        n_head = r_head;
        n_len = r_len;
        n_ok = r_ok;
        o_push = 1'b0;
        o_rec.closed = (r_len != 8'd0);
        o_rec.ident = r_ok && !is_digit(r_head[7:0]) && !kw_match(r_head, r_len);
        o_rec.len = r_len;
        o_rec.line_end = ends_line;
        if (accept) begin
            if (is_sep) begin
                o_push = o_rec.closed || ends_line;
                n_head = '0;
                n_len = 8'd0;
                n_ok = 1'b1;
            end else begin
                if (r_len < 8'(HEAD_BYTES)) begin
                    n_head = r_head | ({56'd0, i_ch} << {r_len[2:0], 3'b000});
                end
                if (!is_word_byte(i_ch)) begin
                    n_ok = 1'b0;
                end
                if (r_len < 8'(TOKEN_LIMIT)) begin
                    n_len = r_len + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_len <= 8'd0;
            r_ok <= 1'b1;
        end else begin
            r_head <= n_head;
            r_len <= n_len;
            r_ok <= n_ok;
        end
    end

endmodule

### sv/citc_queue.sv
// Short queue of token records between the front and the back end.
// Depends on citc_pkg.
module citc_queue
    import citc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_token_rec        i_rec,
    input  logic              i_pop,
    output logic              o_valid,
    output logic              o_full,
    output logic [QCNT_W-1:0] o_count,
    output t_token_rec        o_rec
);

    t_token_rec        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_valid = (r_count != '0);
    assign o_full = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_count = r_count;
    assign o_rec = r_mem[r_rd];
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

### sv/citc_back.sv
// Back end: keeps the per-line identifier count and holds the result register.
// Depends on citc_pkg.
module citc_back
    import citc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_token_rec i_rec,
    output logic       o_pop,
    input  logic       i_ready,
    output logic       o_valid,
    output logic       o_token_closed,
    output logic       o_is_identifier,
    output logic [7:0] o_token_length,
    output logic [6:0] o_identifier_total,
    output logic       o_line_end
);

    logic [6:0] r_count, n_count, total;
    logic       r_valid;

    assign o_valid = r_valid;
    assign o_pop = i_valid && (!r_valid || i_ready);

    always_comb begin
        total = r_count;
        if (i_rec.closed && i_rec.ident && r_count < 7'(COUNT_MAX)) begin
            total = r_count + 7'd1;
        end
        n_count = i_rec.line_end ? 7'd0 : total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= 7'd0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_count <= n_count;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_token_closed <= i_rec.closed;
            o_is_identifier <= i_rec.closed && i_rec.ident;
            o_token_length <= i_rec.closed ? i_rec.len : 8'd0;
            o_identifier_total <= total;
            o_line_end <= i_rec.line_end;
        end
    end

endmodule

### sv/c_identifier_token_counter.sv
// Top level of the C identifier token counter: front end, record queue, back end.
// Depends on citc_pkg, citc_ifs, citc_front, citc_queue and citc_back.

// The block takes one text byte per cycle on i_in while i_in.ready is high
// and splits the line into tokens at spaces; a zero byte or a newline ends
// the line. When a nonempty token ends, or the line ends, one result item
// appears on o_out carrying whether a token closed, whether it is a
// non-keyword C identifier, its length (saturating at the line limit), the
// running identifier count of the line and the line-end flag; the count
// starts over after each line end. The front end classifies a token from its
// registered first eight bytes with a parallel keyword compare and writes the
// record into the queue as the terminating byte is taken; the back end then
// registers the result. A four-entry record queue sits between the classifier
// and the counting output stage, so input bytes keep flowing while results
// wait; only when that queue is full does i_in.ready drop, which happens
// solely when the result side has stalled.
module c_identifier_token_counter
    import citc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    citc_byte_if.sink     i_in,
    citc_result_if.source o_out
);

    t_token_rec        front_rec, queue_rec;
    logic              push, pop, q_valid, q_full;
    logic [QCNT_W-1:0] q_count;

    // Token gathering and classification.
    citc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_ch    (i_in.ch),
        .i_full  (q_full),
        .o_ready (i_in.ready),
        .o_push  (push),
        .o_rec   (front_rec)
    );

    // Decouples the classifier from a stalled result channel.
    citc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_count (q_count),
        .o_rec   (queue_rec)
    );

    // Identifier counting and the result register.
    citc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (q_valid),
        .i_rec              (queue_rec),
        .o_pop              (pop),
        .i_ready            (o_out.ready),
        .o_valid            (o_out.valid),
        .o_token_closed     (o_out.token_closed),
        .o_is_identifier    (o_out.is_identifier),
        .o_token_length     (o_out.token_length),
        .o_identifier_total (o_out.identifier_total),
        .o_line_end         (o_out.line_end)
    );

    // The queue never takes a record while it is full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_full))
        else $error("token record pushed into a full queue");

    // An input stall only comes from a full queue, which in turn means the
    // result register is occupied.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && !i_in.ready) |-> (q_count == QCNT_W'(QUEUE_DEPTH) && o_out.valid))
        else $error("input stalled without a full queue");

    // A reported identifier is always included in the running total.
    a_ident_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_identifier) |-> (o_out.identifier_total != 7'd0))
        else $error("identifier reported with a zero total");

    // A result with no closed token is a bare line end.
    a_bare_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.token_closed) |->
        (o_out.line_end && !o_out.is_identifier && o_out.token_length == 8'd0))
        else $error("empty result that is not a line end");

endmodule

### dv/c_identifier_token_counter_tb.sv
// Testbench for the C identifier token counter: random and directed lines of text in,
// token results checked against an in-bench lexer. Depends on citc_pkg, citc_ifs and the RTL.
module c_identifier_token_counter_tb;
    import citc_pkg::*;

    // One expected result item, field for field as the block presents it.
    typedef struct packed {
        logic       closed;
        logic       ident;
        logic [7:0] len;
        logic [6:0] total;
        logic       line_end;
    } t_lex_result;

    typedef enum int {TK_KEYWORD, TK_NEAR_KEYWORD, TK_NAME, TK_NUMBER, TK_PUNCT, TK_MIXED}
        t_token_kind;
    typedef enum int {NEAR_SUFFIX, NEAR_PREFIX, NEAR_CASE} t_near_kind;

    logic i_clk = 1'b0;
    logic i_rst_n;

    citc_byte_if   in_if ();
    citc_result_if out_if ();

    c_identifier_token_counter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // The C89 keyword set, spelled as text; byte i of a keyword is compared
    // with byte i of the token head.
    string c89_keywords [KEYWORD_COUNT] = '{
        "if", "do", "int", "for", "auto", "char", "case", "long", "enum", "goto",
        "void", "else", "break", "const", "short", "float", "union", "while",
        "double", "return", "extern", "signed", "sizeof", "static", "struct",
        "switch", "default", "typedef", "continue", "register", "unsigned", "volatile"
    };

    // Lexer state mirrored in the bench.
    logic [63:0] tok_head    = '0;
    logic [7:0]  tok_len     = '0;
    logic        tok_word_ok = 1'b1;
    logic [6:0]  line_idents = '0;

    t_lex_result pending_results [$];

    int          error_count = 0;
    int unsigned bytes_sent  = 0;
    int unsigned idle_pct    = 37;   // chance in percent that either side idles in a cycle
    int unsigned hold_left   = 0;    // cycles the result side still refuses items

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Letters, digits and the underscore are the only bytes an identifier may hold.
    function automatic logic is_name_byte(input logic [7:0] c);
        return (c == CH_UNDERSCORE) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    // A token longer than the head can never be a keyword, and a saturated
    // length is always longer than the head.
    function automatic logic is_c_keyword(input logic [63:0] head, input int n);
        logic same;
        if (n == 0 || n > HEAD_BYTES) begin
            return 1'b0;
        end
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            if (c89_keywords[k].len() == n) begin
                same = 1'b1;
                for (int i = 0; i < n; i++) begin
                    if (head[8*i +: 8] != c89_keywords[k][i]) begin
                        same = 1'b0;
                    end
                end
                if (same) begin
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Advances the lexer by one accepted byte and queues the result it causes, if any.
    function automatic void lex_byte(input logic [7:0] c);
        logic        ends_line;
        logic [7:0]  first;
        t_lex_result res;
        ends_line = (c == CH_NUL) || (c == CH_NEWLINE);
        if (!ends_line && c != CH_SPACE) begin
            if (tok_len < HEAD_BYTES) begin
                tok_head[8*tok_len +: 8] = c;
            end
            if (!is_name_byte(c)) begin
                tok_word_ok = 1'b0;
            end
            if (tok_len < TOKEN_LIMIT) begin
                tok_len = tok_len + 8'd1;
            end
            return;
        end
        res = '0;
        if (tok_len != 0) begin
            first = tok_head[7:0];
            res.closed = 1'b1;
            res.len = tok_len;
            res.ident = tok_word_ok && !(first >= 8'h30 && first <= 8'h39) &&
                        !is_c_keyword(tok_head, int'(tok_len));
            if (res.ident && line_idents < COUNT_MAX) begin
                line_idents = line_idents + 7'd1;
            end
        end
        tok_head = '0;
        tok_len = '0;
        tok_word_ok = 1'b1;
        // A space that closes nothing produces no result.
        if (!res.closed && !ends_line) begin
            return;
        end
        res.total = line_idents;
        res.line_end = ends_line;
        pending_results.push_back(res);
        if (ends_line) begin
            line_idents = '0;
        end
    endfunction

    // Offers one byte, with random idle cycles ahead of it, and waits until it is taken.
    task automatic send_char(input logic [7:0] c);
        @(negedge i_clk);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.ch <= c;
        do @(posedge i_clk); while (!in_if.ready);
        lex_byte(c);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    function automatic logic [7:0] pick_name_char(input bit digits_ok);
        int r;
        r = $urandom_range(0, digits_ok ? 62 : 52);
        if (r < 26) begin
            return 8'(8'h61 + r);
        end
        if (r < 52) begin
            return 8'(8'h41 + r - 26);
        end
        if (r == 52) begin
            return CH_UNDERSCORE;
        end
        return 8'(8'h30 + r - 53);
    endfunction

    // Any byte that stays inside a token: not a separator and not a terminator.
    function automatic logic [7:0] pick_token_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_NEWLINE || c == CH_SPACE);
        return c;
    endfunction

    task automatic send_random_token();
        t_token_kind kind;
        t_near_kind  near;
        string       kw;
        int          roll, n, j;
        roll = $urandom_range(0, 9);
        kind = (roll < 3) ? TK_KEYWORD : (roll < 4) ? TK_NEAR_KEYWORD :
               (roll < 7) ? TK_NAME : (roll < 8) ? TK_NUMBER :
               (roll < 9) ? TK_PUNCT : TK_MIXED;
        kw = c89_keywords[$urandom_range(0, KEYWORD_COUNT - 1)];
        case (kind)
            TK_KEYWORD: begin
                send_text(kw);
            end
            TK_NEAR_KEYWORD: begin
                // Words that differ from a keyword by one byte, a missing byte or an extra one.
                near = t_near_kind'($urandom_range(0, 2));
                case (near)
                    NEAR_SUFFIX: begin
                        send_text(kw);
                        send_char(pick_name_char(1'b1));
                    end
                    NEAR_PREFIX: begin
                        for (int i = 0; i < kw.len() - 1; i++) begin
                            send_char(kw[i]);
                        end
                    end
                    default: begin
                        n = $urandom_range(0, kw.len() - 1);
                        for (int i = 0; i < kw.len(); i++) begin
                            send_char((i == n) ? (kw[i] ^ 8'h20) : kw[i]);
                        end
                    end
                endcase
            end
            TK_NAME: begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
                send_char(pick_name_char(1'b0));
                for (int i = 1; i < n; i++) begin
                    send_char(pick_name_char(1'b1));
                end
            end
            TK_NUMBER: begin
                send_char(8'(8'h30 + $urandom_range(0, 9)));
                repeat ($urandom_range(0, 5)) send_char(pick_name_char(1'b1));
            end
            TK_PUNCT: begin
                repeat ($urandom_range(1, 6)) send_char(pick_token_byte());
            end
            default: begin
                // A word with one foreign byte somewhere in it.
                n = $urandom_range(2, 8);
                j = $urandom_range(0, n - 1);
                for (int i = 0; i < n; i++) begin
                    send_char((i == j) ? pick_token_byte() : pick_name_char(i != 0));
                end
            end
        endcase
    endtask

    // Mostly well-formed lines of random tokens; now and then a line of raw bytes.
    task automatic send_random_line();
        int n_tok;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 15)) send_char(8'($urandom_range(0, 255)));
            send_char(CH_NEWLINE);
            return;
        end
        n_tok = $urandom_range(0, 8);
        repeat ($urandom_range(0, 2)) send_char(CH_SPACE);
        for (int k = 0; k < n_tok; k++) begin
            send_random_token();
            if (k < n_tok - 1) begin
                repeat ($urandom_range(1, 3)) send_char(CH_SPACE);
            end else begin
                repeat ($urandom_range(0, 2)) send_char(CH_SPACE);
            end
        end
        send_char($urandom_range(0, 1) ? CH_NUL : CH_NEWLINE);
    endtask

    // Lines that hold nothing, or only spaces, still report the line end.
    task automatic test_empty_lines();
        send_char(CH_NEWLINE);
        send_char(CH_NUL);
        send_text("   ");
        send_char(CH_NEWLINE);
    endtask

    // Underscore start, digit start, keyword, keyword with case changed, punctuation
    // inside a word, and bytes with the top bit set.
    task automatic test_token_classes();
        send_text("_9 9 if Int typedef a-b ");
        send_char(8'h80);
        send_char(8'hFF);
        send_char(CH_NUL);
    endtask

    task automatic test_keyword_table();
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            send_text(c89_keywords[k]);
            send_char(CH_SPACE);
        end
        send_char(CH_NEWLINE);
    endtask

    // A nine-byte word that starts with an eight-byte keyword, then a word long
    // enough to saturate the length and closed by a zero byte.
    task automatic test_long_tokens();
        send_text("volatile_ ");
        send_char(pick_name_char(1'b0));
        repeat (TOKEN_LIMIT + 2) send_char(pick_name_char(1'b1));
        send_char(CH_NUL);
    endtask

    // More identifiers in one line than the counter can hold.
    task automatic test_count_saturation();
        repeat (COUNT_MAX + 3) begin
            send_char(pick_name_char(1'b0));
            send_char(CH_SPACE);
        end
        send_char(CH_NEWLINE);
        send_text("a");
        send_char(CH_NEWLINE);
    endtask

    // The result side refuses items for a long stretch while short tokens keep
    // arriving, so the record queue fills and the input must stall.
    task automatic test_backpressure();
        hold_left = 150;
        repeat (20) begin
            send_char(pick_name_char(1'b0));
            send_char(CH_SPACE);
        end
        send_char(CH_NEWLINE);
    endtask

    task automatic test_steady_stream();
        int unsigned stop_at;
        idle_pct = 0;
        stop_at = bytes_sent + 40;
        while (bytes_sent < stop_at) begin
            send_random_line();
        end
        idle_pct = 37;
    endtask

    task automatic test_random_lines(input int unsigned n_bytes);
        int unsigned stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            send_random_line();
        end
    endtask

    task automatic check_result();
        t_lex_result want;
        if (pending_results.size() == 0) begin
            $error("result item with none expected: token_length %0d line_end %0b",
                   out_if.token_length, out_if.line_end);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (out_if.token_closed !== want.closed) begin
            $error("token_closed: expected %0b, got %0b", want.closed, out_if.token_closed);
            error_count++;
        end
        if (out_if.is_identifier !== want.ident) begin
            $error("is_identifier: expected %0b, got %0b", want.ident, out_if.is_identifier);
            error_count++;
        end
        if (out_if.token_length !== want.len) begin
            $error("token_length: expected %0d, got %0d", want.len, out_if.token_length);
            error_count++;
        end
        if (out_if.identifier_total !== want.total) begin
            $error("identifier_total: expected %0d, got %0d", want.total,
                   out_if.identifier_total);
            error_count++;
        end
        if (out_if.line_end !== want.line_end) begin
            $error("line_end: expected %0b, got %0b", want.line_end, out_if.line_end);
            error_count++;
        end
    endtask

    // Result side: ready changes at the falling edge, items are taken at the rising edge.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= !(idle_pct != 0 && $urandom_range(99) < idle_pct);
            end
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                check_result();
            end
        end
    end

    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        in_if.valid = 1'b0;
        in_if.ch = CH_NUL;
        i_rst_n = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_lines();
        test_token_classes();
        test_keyword_table();
        test_long_tokens();
        test_count_saturation();
        test_backpressure();
        test_steady_stream();
        test_random_lines(40);

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        // Let a stray late result show itself before the verdict.
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
